// File: sv/csu_pkg.sv
`default_nettype none

package csu_pkg;

  // Longest vector that is accumulated; further pairs only raise the overflow flag.
  localparam int unsigned MAX_LENGTH = 4096;

  // Field and datapath widths.
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 44;
  localparam int CNT_W     = $clog2(MAX_LENGTH + 2);
  localparam int HALF_W    = ACC_W / 2;
  localparam int PART_W    = 2 * HALF_W;
  localparam int WIDE_W    = 2 * ACC_W;
  localparam int REM_W     = WIDE_W + 1;
  localparam int QUO_W     = 32;
  localparam int DIV_STEPS = QUO_W - 1;
  localparam int ROOT_W    = QUO_W / 2;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int MUL_STEPS = 8;
  localparam int STEP_W    = 5;

  // Largest positive Q1.15 value.
  localparam logic [ROOT_W-2:0] Q_MAX = '1;

  // Job queue between the accumulator and the divider.
  localparam int JQ_DEPTH = 2;
  localparam int JQ_IDX_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int JQ_LVL_W = $clog2(JQ_DEPTH + 1);

  // One finished vector: its sums and the overflow flag.
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        sqa;
    logic [ACC_W-1:0]        sqb;
    logic                    ovf;
  } job_t;

  // One result item.
  typedef struct packed {
    logic signed [ELEM_W-1:0] sim;
    logic                     zden;
    logic                     ovf;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// File: sv/cosine_similarity_unit.sv
`default_nettype none

// Channel   Handshake            Payload
// input     push / full          elem_a, elem_b, last_pair
// result    empty / pop          similarity, zero_denominator, length_overflow
//
// Element pairs are taken at one a cycle while full is low; a product stage feeds the
// three accumulators. Each vector's last pair hands a job to a two-entry queue ahead
// of the divider. The back end runs eight 22x22 partial products, 31 restoring division
// steps and 16 square-root steps; the last two are skipped when the denominator is zero.
// The input reports full while the queue and the vector in the product stage fill it.
// Reset is synchronous and clears the count, sums, queue and the result valid flag.

module cosine_similarity_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [csu_pkg::ELEM_W-1:0] elem_a,
  input  wire logic signed [csu_pkg::ELEM_W-1:0] elem_b,
  input  wire logic                              last_pair,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [csu_pkg::ELEM_W-1:0]      similarity,
  output logic                                   zero_denominator,
  output logic                                   length_overflow
);

  logic                              q_push;
  csu_pkg::job_t                     q_in;
  logic                              q_pop;
  logic                              q_valid;
  csu_pkg::job_t                     q_head;
  logic [csu_pkg::JQ_LVL_W-1:0]      q_level;
  logic                              res_valid;
  csu_pkg::res_t                     res;

  // Front end: products and running sums.
  csu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .elem_a    (elem_a),
    .elem_b    (elem_b),
    .last_pair (last_pair),
    .q_level   (q_level),
    .q_push    (q_push),
    .q_job     (q_in)
  );

  // Finished vectors wait here for the divider.
  csu_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_job   (q_in),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_head),
    .level    (q_level)
  );

  // Back end: normalisation by the magnitudes.
  csu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_head),
    .job_pop   (q_pop),
    .out_valid (res_valid),
    .out_res   (res),
    .out_pop   (pop)
  );

  assign empty            = ~res_valid;
  assign similarity       = res.sim;
  assign zero_denominator = res.zden;
  assign length_overflow  = res.ovf;

endmodule

`default_nettype wire

// File: sv/csu_front.sv
`default_nettype none

module csu_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [csu_pkg::ELEM_W-1:0]   elem_a,
  input  wire logic signed [csu_pkg::ELEM_W-1:0]   elem_b,
  input  wire logic                                last_pair,
  input  wire logic [csu_pkg::JQ_LVL_W-1:0]        q_level,
  output logic                                     q_push,
  output csu_pkg::job_t                            q_job
);

  logic                                  accept;
  logic [csu_pkg::CNT_W-1:0]             pair_count;
  logic [csu_pkg::CNT_W-1:0]             pair_count_next;
  logic                                  s1_valid;
  logic                                  s1_last;
  logic                                  s1_en;
  logic                                  s1_ovf;
  logic signed [csu_pkg::PROD_W-1:0]     s1_ab;
  logic signed [csu_pkg::PROD_W-1:0]     s1_aa;
  logic signed [csu_pkg::PROD_W-1:0]     s1_bb;
  logic signed [csu_pkg::ACC_W-1:0]      dot_sum;
  logic signed [csu_pkg::ACC_W-1:0]      dot_upd;
  logic [csu_pkg::ACC_W-1:0]             sq_a;
  logic [csu_pkg::ACC_W-1:0]             sq_a_upd;
  logic [csu_pkg::ACC_W-1:0]             sq_b;
  logic [csu_pkg::ACC_W-1:0]             sq_b_upd;
  logic [csu_pkg::JQ_LVL_W:0]            booked;

  // A request is refused unless a queue slot is free for every vector in flight.
  assign booked = {1'b0, q_level} + (csu_pkg::JQ_LVL_W + 1)'(s1_valid & s1_last);
  assign full   = booked >= (csu_pkg::JQ_LVL_W + 1)'(csu_pkg::JQ_DEPTH);
  assign accept = push & ~full;

  // The pair count saturates one above the limit and restarts after the last pair.
  always_comb begin
    pair_count_next = pair_count;
    if (accept) begin
      if (last_pair) begin
        pair_count_next = '0;
      end else if (pair_count <= csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH)) begin
        pair_count_next = pair_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      s1_valid   <= 1'b0;
    end else begin
      pair_count <= pair_count_next;
      s1_valid   <= accept;
    end
  end

  // Product stage: the three products of one pair, and whether it counts.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ab   <= elem_a * elem_b;
      s1_aa   <= elem_a * elem_a;
      s1_bb   <= elem_b * elem_b;
      s1_last <= last_pair;
      s1_en   <= pair_count < csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH);
      s1_ovf  <= pair_count >= csu_pkg::CNT_W'(csu_pkg::MAX_LENGTH);
    end
  end

  // Running sums including the pair in the product stage.
  always_comb begin
    dot_upd  = dot_sum;
    sq_a_upd = sq_a;
    sq_b_upd = sq_b;
    if (s1_en) begin
      dot_upd  = dot_sum + {{(csu_pkg::ACC_W - csu_pkg::PROD_W){s1_ab[csu_pkg::PROD_W-1]}}, s1_ab};
      sq_a_upd = sq_a + {{(csu_pkg::ACC_W - csu_pkg::PROD_W){1'b0}}, s1_aa};
      sq_b_upd = sq_b + {{(csu_pkg::ACC_W - csu_pkg::PROD_W){1'b0}}, s1_bb};
    end
  end

  // Accumulators clear once the last pair has been handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum <= '0;
      sq_a    <= '0;
      sq_b    <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        dot_sum <= '0;
        sq_a    <= '0;
        sq_b    <= '0;
      end else begin
        dot_sum <= dot_upd;
        sq_a    <= sq_a_upd;
        sq_b    <= sq_b_upd;
      end
    end
  end

  // A finished vector becomes one job for the back end.
  assign q_push    = s1_valid & s1_last;
  assign q_job.dot = dot_upd;
  assign q_job.sqa = sq_a_upd;
  assign q_job.sqb = sq_b_upd;
  assign q_job.ovf = s1_ovf;

endmodule

`default_nettype wire

// File: sv/csu_job_queue.sv
`default_nettype none

module csu_job_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire csu_pkg::job_t                 wr_job,
  input  wire logic                          rd_en,
  output logic                               rd_valid,
  output csu_pkg::job_t                      rd_job,
  output logic [csu_pkg::JQ_LVL_W-1:0]       level
);

  csu_pkg::job_t                  entries [csu_pkg::JQ_DEPTH];
  logic [csu_pkg::JQ_IDX_W-1:0]   wr_ptr;
  logic [csu_pkg::JQ_IDX_W-1:0]   rd_ptr;
  logic                           do_wr;
  logic                           do_rd;

  assign rd_valid = level != '0;
  assign rd_job   = entries[rd_ptr];
  assign do_wr    = wr_en & (level != csu_pkg::JQ_LVL_W'(csu_pkg::JQ_DEPTH));
  assign do_rd    = rd_en & rd_valid;

  // Storage is written in order; the head is read from the read pointer.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Pointers wrap at the depth; the level tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == csu_pkg::JQ_IDX_W'(csu_pkg::JQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == csu_pkg::JQ_IDX_W'(csu_pkg::JQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr & ~do_rd) begin
        level <= level + 1'b1;
      end else if (do_rd & ~do_wr) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/csu_back.sv
`default_nettype none

module csu_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  input  wire csu_pkg::job_t     job,
  output logic                   job_pop,
  output logic                   out_valid,
  output csu_pkg::res_t          out_res,
  input  wire logic              out_pop
);

  csu_pkg::back_state_t              state;
  csu_pkg::back_state_t              state_next;
  logic                              out_load;
  logic [csu_pkg::STEP_W-1:0]        step;
  logic                              neg;
  logic                              ovf;
  logic                              zden;
  logic [csu_pkg::ACC_W-1:0]         mag;
  logic [csu_pkg::ACC_W-1:0]         sqa;
  logic [csu_pkg::ACC_W-1:0]         sqb;
  logic [csu_pkg::HALF_W-1:0]        x_op;
  logic [csu_pkg::HALF_W-1:0]        y_op;
  logic [csu_pkg::PART_W-1:0]        part;
  logic [2:0]                        part_sel;
  logic [csu_pkg::WIDE_W-1:0]        part_sh;
  logic [csu_pkg::WIDE_W-1:0]        p_acc;
  logic [csu_pkg::WIDE_W-1:0]        d_acc;
  logic [csu_pkg::REM_W-1:0]         rem;
  logic [csu_pkg::REM_W-1:0]         divisor;
  logic [csu_pkg::QUO_W-1:0]         quo;
  logic [csu_pkg::SREM_W-1:0]        srem;
  logic [csu_pkg::SREM_W-1:0]        srem_try;
  logic [csu_pkg::SREM_W-1:0]        trial;
  logic [csu_pkg::ROOT_W-1:0]        root;
  logic [csu_pkg::ROOT_W-2:0]        q_mag;
  logic signed [csu_pkg::ELEM_W-1:0] sim;
  logic                              mul_last;
  logic                              p_small;

  assign mul_last = step == csu_pkg::STEP_W'(csu_pkg::MUL_STEPS);
  assign p_small  = p_acc <= csu_pkg::WIDE_W'(1);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csu_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: multiply, divide and root unless the denominator is zero, then hand the result on.
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    out_load   = 1'b0;
    case (state)
      csu_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = csu_pkg::BK_MUL;
        end
      end
      csu_pkg::BK_MUL: begin
        if (mul_last) begin
          state_next = csu_pkg::BK_PREP;
        end
      end
      csu_pkg::BK_PREP: begin
        state_next = p_small ? csu_pkg::BK_DONE : csu_pkg::BK_DIV;
      end
      csu_pkg::BK_DIV: begin
        if (step == '0) begin
          state_next = csu_pkg::BK_SQRT;
        end
      end
      csu_pkg::BK_SQRT: begin
        if (step == '0) begin
          state_next = csu_pkg::BK_DONE;
        end
      end
      csu_pkg::BK_DONE: begin
        if (~out_valid | out_pop) begin
          out_load   = 1'b1;
          state_next = csu_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = csu_pkg::BK_IDLE;
      end
    endcase
  end

  // Partial-product operands: four for the magnitude product, four for the dot square.
  always_comb begin
    if (step[2]) begin
      x_op = step[0] ? mag[csu_pkg::ACC_W-1:csu_pkg::HALF_W] : mag[csu_pkg::HALF_W-1:0];
      y_op = step[1] ? mag[csu_pkg::ACC_W-1:csu_pkg::HALF_W] : mag[csu_pkg::HALF_W-1:0];
    end else begin
      x_op = step[0] ? sqa[csu_pkg::ACC_W-1:csu_pkg::HALF_W] : sqa[csu_pkg::HALF_W-1:0];
      y_op = step[1] ? sqb[csu_pkg::ACC_W-1:csu_pkg::HALF_W] : sqb[csu_pkg::HALF_W-1:0];
    end
  end

  // Place the registered partial product by the halves it came from.
  always_comb begin
    case ({part_sel[1], part_sel[0]})
      2'b00:   part_sh = csu_pkg::WIDE_W'(part);
      2'b11:   part_sh = csu_pkg::WIDE_W'(part) << (2 * csu_pkg::HALF_W);
      default: part_sh = csu_pkg::WIDE_W'(part) << csu_pkg::HALF_W;
    endcase
  end

  // Division and square-root step terms.
  assign divisor  = {1'b0, p_acc};
  assign srem_try = {srem[csu_pkg::SREM_W-3:0], quo[csu_pkg::QUO_W-1:csu_pkg::QUO_W-2]};
  assign trial    = {root, 2'b01};

  // Clamp the root to Q1.15 and apply the sign of the dot product.
  always_comb begin
    q_mag = root[csu_pkg::ROOT_W-1] ? csu_pkg::Q_MAX : root[csu_pkg::ROOT_W-2:0];
    if (zden) begin
      sim = '0;
    end else if (neg) begin
      sim = -$signed({1'b0, q_mag});
    end else begin
      sim = $signed({1'b0, q_mag});
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      csu_pkg::BK_IDLE: begin
        if (job_valid) begin
          neg   <= job.dot[csu_pkg::ACC_W-1];
          mag   <= job.dot[csu_pkg::ACC_W-1] ? csu_pkg::ACC_W'(-job.dot) : job.dot;
          sqa   <= job.sqa;
          sqb   <= job.sqb;
          ovf   <= job.ovf;
          p_acc <= '0;
          d_acc <= '0;
          step  <= '0;
        end
      end
      csu_pkg::BK_MUL: begin
        if (!mul_last) begin
          part     <= x_op * y_op;
          part_sel <= step[2:0];
        end
        if (step != '0) begin
          if (part_sel[2]) begin
            d_acc <= d_acc + part_sh;
          end else begin
            p_acc <= p_acc + part_sh;
          end
        end
        step <= step + 1'b1;
      end
      csu_pkg::BK_PREP: begin
        zden <= p_small;
        rem  <= {1'b0, d_acc};
        quo  <= '0;
        step <= csu_pkg::STEP_W'(csu_pkg::DIV_STEPS - 1);
      end
      csu_pkg::BK_DIV: begin
        // One quotient bit of dot^2 * 2^30 / (sqa * sqb) per cycle.
        if (rem >= divisor) begin
          rem <= (rem - divisor) << 1;
          quo <= {quo[csu_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem <= rem << 1;
          quo <= {quo[csu_pkg::QUO_W-2:0], 1'b0};
        end
        if (step == '0) begin
          srem <= '0;
          root <= '0;
          step <= csu_pkg::STEP_W'(csu_pkg::ROOT_W - 1);
        end else begin
          step <= step - 1'b1;
        end
      end
      csu_pkg::BK_SQRT: begin
        // One root bit per cycle, two radicand bits brought down.
        if (srem_try >= trial) begin
          srem <= srem_try - trial;
          root <= {root[csu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem <= srem_try;
          root <= {root[csu_pkg::ROOT_W-2:0], 1'b0};
        end
        quo  <= quo << 2;
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res.sim  <= sim;
      out_res.zden <= zden;
      out_res.ovf  <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: verif/cosine_similarity_unit_tb.sv
`timescale 1ns / 100ps

module cosine_similarity_unit_tb;
  import csu_pkg::*;

  localparam int          BIG_W          = 160;
  localparam int          RANDOM_PAIRS   = 1950;
  localparam int          HOLD_CYCLES    = 500;
  localparam int          TAIL_CYCLES    = 200;
  localparam int unsigned CYCLE_LIMIT    = 4000000;
  localparam logic signed [ELEM_W-1:0] MOST_NEG = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] MOST_POS = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] SAT_POS  = 16'sd32767;
  localparam logic signed [ELEM_W-1:0] SAT_NEG  = -16'sd32767;

  // Flavours of random vector content.
  typedef enum int {
    KIND_FULL,
    KIND_TINY,
    KIND_PARALLEL,
    KIND_OPPOSED,
    KIND_NEAR,
    KIND_ONE_SIDED,
    KIND_EXTREME,
    KIND_SINGLE_BIT
  } vec_kind_t;

  // One row of the directed stimulus; want is used only where typed is set.
  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     last;
    logic                     typed;
    res_t                     want;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic signed [ELEM_W-1:0] elem_a = '0;
  logic signed [ELEM_W-1:0] elem_b = '0;
  logic                     last_pair = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [ELEM_W-1:0] similarity;
  logic                     zero_denominator;
  logic                     length_overflow;

  // Hand-typed expectation travelling alongside a directed request.
  logic typed_valid = 1'b0;
  res_t typed_want = '0;

  // Predictor state: the running sums and pair count of the current vector.
  logic signed [ACC_W-1:0] dot_acc = '0;
  logic [ACC_W-1:0]        sq_a_acc = '0;
  logic [ACC_W-1:0]        sq_b_acc = '0;
  int unsigned             pairs_seen = 0;

  res_t        predicted_scores[$];
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned pairs_taken = 0;
  int unsigned scores_checked = 0;
  int unsigned zden_seen = 0;
  int unsigned ovf_seen = 0;
  int unsigned saturated_seen = 0;
  bit          produced;
  res_t        predicted;
  res_t        oldest;

  cosine_similarity_unit dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .elem_a           (elem_a),
    .elem_b           (elem_b),
    .last_pair        (last_pair),
    .empty            (empty),
    .pop              (pop),
    .similarity       (similarity),
    .zero_denominator (zero_denominator),
    .length_overflow  (length_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Folds one pair into the running sums and, on the last pair, works out the score.
  task automatic fold_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                           input logic last, output bit has_score, output res_t score);
    logic signed [ACC_W-1:0] prod;
    logic [ACC_W-1:0]        mag;
    logic [BIG_W-1:0]        denom_sq;
    logic [BIG_W-1:0]        numer_sq;
    logic [ELEM_W-1:0]       q;
    logic [ELEM_W-1:0]       trial;
    logic                    neg;
    has_score = 1'b0;
    score = '0;
    if (pairs_seen < MAX_LENGTH) begin
      prod = a * b;
      dot_acc = dot_acc + prod;
      prod = a * a;
      sq_a_acc = sq_a_acc + prod;
      prod = b * b;
      sq_b_acc = sq_b_acc + prod;
    end
    if (pairs_seen <= MAX_LENGTH) pairs_seen++;
    if (last) begin
      has_score = 1'b1;
      score.ovf = (pairs_seen > MAX_LENGTH);
      denom_sq = BIG_W'(sq_a_acc) * BIG_W'(sq_b_acc);
      score.zden = (denom_sq <= 1);
      if (!score.zden) begin
        // Largest q with q^2 * sa * sb <= 2^30 * dot^2, found bit by bit.
        neg = dot_acc[ACC_W-1];
        mag = neg ? -dot_acc : dot_acc;
        numer_sq = (BIG_W'(mag) * BIG_W'(mag)) << 30;
        q = '0;
        for (int i = ELEM_W - 2; i >= 0; i--) begin
          trial = q | (16'd1 << i);
          if (denom_sq * BIG_W'(trial) * BIG_W'(trial) <= numer_sq) q = trial;
        end
        score.sim = neg ? -q : q;
      end
      dot_acc = '0;
      sq_a_acc = '0;
      sq_b_acc = '0;
      pairs_seen = 0;
    end
  endtask

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ELEM_W-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return -16'sd1;
      3: return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic make_pair(input vec_kind_t kind, output logic signed [ELEM_W-1:0] a,
                           output logic signed [ELEM_W-1:0] b);
    logic signed [ELEM_W-1:0] base;
    base = ELEM_W'($urandom_range(0, 65535));
    case (kind)
      KIND_FULL: begin
        a = base;
        b = ELEM_W'($urandom_range(0, 65535));
      end
      KIND_TINY: begin
        a = ELEM_W'($urandom_range(0, 6) - 3);
        b = ELEM_W'($urandom_range(0, 6) - 3);
      end
      KIND_PARALLEL: begin
        a = base;
        b = base;
      end
      KIND_OPPOSED: begin
        a = base;
        b = -base;
      end
      KIND_NEAR: begin
        a = base;
        b = base + ELEM_W'($urandom_range(0, 6) - 3);
      end
      KIND_ONE_SIDED: begin
        if ($urandom_range(0, 1) == 0) begin
          a = base;
          b = '0;
        end else begin
          a = '0;
          b = base;
        end
      end
      KIND_EXTREME: begin
        a = extreme_value();
        b = extreme_value();
      end
      default: begin
        a = 16'd1 << $urandom_range(0, 15);
        b = 16'd1 << $urandom_range(0, 15);
      end
    endcase
  endtask

  // Offers one request and waits for it to be taken, then idles for a while.
  task automatic send_pair(input logic signed [ELEM_W-1:0] a, input logic signed [ELEM_W-1:0] b,
                           input logic last, input logic typed, input res_t want);
    int unsigned gap;
    @(negedge clk);
    push <= 1'b1;
    elem_a <= a;
    elem_b <= b;
    last_pair <= last;
    typed_valid <= typed;
    typed_want <= want;
    do @(posedge clk); while (full);
    gap = steady ? 0 : idle_length();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic send_vector(input int unsigned len, input vec_kind_t kind);
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      make_pair(kind, a, b);
      send_pair(a, b, i == len - 1, 1'b0, '0);
    end
  endtask

  function automatic int unsigned vector_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    else if (r < 85) return $urandom_range(5, 16);
    else return $urandom_range(17, 64);
  endfunction

  // Stops offering requests, then waits until every expected result has been taken.
  task automatic wait_for_drain();
    @(negedge clk);
    push <= 1'b0;
    while (predicted_scores.size() != 0) @(posedge clk);
  endtask

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL cosine_similarity_unit");
      $finish;
    end
  end

  // Predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        pairs_taken++;
        fold_pair(elem_a, elem_b, last_pair, produced, predicted);
        if (produced) predicted_scores.push_back(typed_valid ? typed_want : predicted);
      end
      if (pop && !empty) begin
        if (predicted_scores.size() == 0) begin
          $error("unexpected result: similarity %0d", similarity);
          error_count++;
        end else begin
          oldest = predicted_scores.pop_front();
          scores_checked++;
          if (zero_denominator) zden_seen++;
          if (length_overflow) ovf_seen++;
          if (similarity == SAT_POS) saturated_seen++;
          if (similarity !== oldest.sim) begin
            $error("similarity: expected %0d, got %0d", oldest.sim, similarity);
            error_count++;
          end
          if (zero_denominator !== oldest.zden) begin
            $error("zero_denominator: expected %0d, got %0d", oldest.zden, zero_denominator);
            error_count++;
          end
          if (length_overflow !== oldest.ovf) begin
            $error("length_overflow: expected %0d, got %0d", oldest.ovf, length_overflow);
            error_count++;
          end
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request from the sender.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!steady) stall_left = idle_length();
      end
    end
  end

  // Input side: reset, directed rows, then random vectors with pressure phases.
  initial begin : sender
    directed_row_t directed_rows[22];
    int unsigned   random_pairs;
    int unsigned   vector_index;
    int unsigned   len;

    directed_rows = '{
      '{16'sd0,    16'sd0,    1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{MOST_POS,  16'sd0,    1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{16'sd0,    MOST_NEG,  1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{16'sd1,    16'sd1,    1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{-16'sd1,   16'sd1,    1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{16'sd2,    16'sd2,    1'b1, 1'b1, '{SAT_POS, 1'b0, 1'b0}},
      '{MOST_POS,  MOST_POS,  1'b1, 1'b1, '{SAT_POS, 1'b0, 1'b0}},
      '{MOST_NEG,  MOST_NEG,  1'b1, 1'b1, '{SAT_POS, 1'b0, 1'b0}},
      '{MOST_NEG,  MOST_POS,  1'b1, 1'b1, '{SAT_NEG, 1'b0, 1'b0}},
      '{MOST_POS,  MOST_NEG,  1'b1, 1'b1, '{SAT_NEG, 1'b0, 1'b0}},
      '{16'sd100,  16'sd0,    1'b0, 1'b0, '0},
      '{16'sd0,    16'sd100,  1'b1, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{16'sd1000, -16'sd2000, 1'b0, 1'b0, '0},
      '{-16'sd3000, 16'sd6000, 1'b1, 1'b1, '{SAT_NEG, 1'b0, 1'b0}},
      '{16'sd1,    16'sd2,    1'b0, 1'b0, '0},
      '{16'sd0,    16'sd0,    1'b0, 1'b0, '0},
      '{-16'sd2,   -16'sd1,   1'b1, 1'b0, '0},
      '{16'sd16384, MOST_NEG, 1'b0, 1'b0, '0},
      '{-16'sd1,   MOST_POS,  1'b0, 1'b0, '0},
      '{MOST_POS,  16'sd1,    1'b1, 1'b0, '0},
      '{16'sd3,    16'sd4,    1'b0, 1'b0, '0},
      '{16'sd4,    -16'sd3,   1'b1, 1'b1, '{16'sd0, 1'b0, 1'b0}}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);

    random_pairs = 0;
    vector_index = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      if (vector_index == 20) begin
        // Hold the result side off while one-pair vectors keep coming, so the input stalls.
        hold_request = 1'b1;
        repeat (30) send_vector(1, vec_kind_t'($urandom_range(0, 7)));
      end
      if (vector_index == 60) wait_for_drain();
      if (vector_index == 100) steady = 1'b1;
      if (vector_index == 130) steady = 1'b0;
      if (vector_index == 120) begin
        // A vector one pair past the length limit.
        send_vector(MAX_LENGTH + 1, KIND_FULL);
      end
      len = vector_length();
      send_vector(len, vec_kind_t'($urandom_range(0, 7)));
      random_pairs += len;
      vector_index++;
    end

    @(negedge clk);
    push <= 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d pairs: %0d with zero denominator, %0d over length,",
             scores_checked, pairs_taken, zden_seen, ovf_seen);
    $display("%0d saturated, with long result hold-off, drain pause and unbroken streaming.",
             saturated_seen);
    if (error_count == 0) begin
      $display("PASS cosine_similarity_unit");
    end else begin
      $display("FAIL cosine_similarity_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/csu_pkg.sv
sv/csu_front.sv
sv/csu_job_queue.sv
sv/csu_back.sv
sv/cosine_similarity_unit.sv
verif/cosine_similarity_unit_tb.sv
